[rtl/pdps_pkg.sv]
// ---------------------------------------------------------------------------
// pdps_pkg: shared types and constants of the density evaluator
// Field widths, fixed-point constants, register indexes and the side-band
// record that travels alongside the expansivity pipeline.
// ---------------------------------------------------------------------------
package pdps_pkg;

   localparam int T_W     = 21;  // temperature, 1/256 K
   localparam int P_W     = 28;  // pressure, kPa
   localparam int AE_W    = 32;  // input expansivity
   localparam int BE_W    = 32;  // input compressibility
   localparam int DEN_W   = 32;  // density, 1/65536 kg/m3
   localparam int PH_W    = 2;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 3;

   localparam int DT_W    = T_W + 1;          // signed temperature difference
   localparam int DP_W    = P_W + 1;          // signed pressure difference
   localparam int PRESS_W = BE_W + DP_W;      // compressibility term
   localparam int SLOPE_W = 15;
   localparam int BND_W   = P_W + 2;          // phase boundary
   localparam int BASE_W  = DEN_W + 3;        // base density with steps

   localparam int H_W     = 46;               // Horner accumulator
   localparam int PC_W    = P_W - 1;          // clamped pressure
   localparam int PFAC_W  = 23;
   localparam int D_W     = 51;               // pressure divisor
   localparam int R_W     = D_W + 1;          // divider remainder
   localparam int DIV_STEPS = 40;             // quotient bits
   localparam int ALPHA_W = DIV_STEPS + 1;
   localparam int THERM_W = ALPHA_W + DT_W;
   localparam int F_W     = 62;               // expansion factor, scale 2^-48
   localparam int BM_W    = BASE_W - 1;
   localparam int FM_W    = F_W - 1;
   localparam int FLO_W   = 31;
   localparam int FHI_W   = FM_W - FLO_W;
   localparam int PROD_W  = BM_W + FM_W;
   localparam int FRAC_SH = 48;

   localparam int POLY_STAGES = 4;

   localparam logic signed [SLOPE_W-1:0] FIRST_SLOPE_DEFAULT  = '0;
   localparam logic signed [SLOPE_W-1:0] SECOND_SLOPE_DEFAULT = '0;

   localparam logic signed [DT_W-1:0] T273 = 22'sd69888;
   localparam logic [PFAC_W-1:0] PFAC = 23'd7864411;
   localparam logic [D_W-1:0] ONE48_D = 51'd1 << FRAC_SH;
   localparam logic signed [63:0] ONE48 = 64'sd1 <<< FRAC_SH;

   // Horner coefficients, highest order first, and the shift after each step.
   localparam logic signed [H_W-1:0] POLY_COEF [POLY_STAGES+1] = '{
      -46'sd638483916068, 46'sd945844218453, -46'sd124410744991,
      46'sd30195014206, 46'sd1321440573};
   localparam int POLY_SHIFT [POLY_STAGES] = '{20, 22, 20, 18};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_DENSITY, CSR_REF_TEMP, CSR_REF_PRES, CSR_POLY_MODE,
      CSR_STEP1_PRES, CSR_STEP1_DEN, CSR_STEP2_PRES, CSR_STEP2_DEN
   } csr_index_type;

   typedef enum logic [PH_W-1:0] {
      PHASE_LOW, PHASE_MID, PHASE_HIGH
   } phase_type;

   typedef struct packed {
      logic                      tv;
      logic                      pv;
      logic signed [AE_W-1:0]    alpha_in;
      logic signed [DT_W-1:0]    dt;
      logic signed [PRESS_W-1:0] press;
      phase_type                 phase;
      logic signed [BASE_W-1:0]  base;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

endpackage

[rtl/pdps_pipe_ctl.sv]
// ---------------------------------------------------------------------------
// pdps_pipe_ctl: valid and load-enable control of a chain of stages
// Each stage loads when it is empty or when the stage after it moves on,
// so bubbles close up and a stall holds every item in place.
// ---------------------------------------------------------------------------
module pdps_pipe_ctl #(
   parameter int STAGES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [STAGES-1:0] stage_en
);

   logic [STAGES-1:0] valid_ff, valid_in, ready;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      if (i == STAGES - 1) begin : g_last
         assign ready[i] = !valid_ff[i] || out_ready;
      end else begin : g_mid
         assign ready[i] = !valid_ff[i] || ready[i+1];
      end
      if (i == 0) begin : g_first
         assign valid_in[i] = ready[i] ? in_valid : valid_ff[i];
      end else begin : g_next
         assign valid_in[i] = ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[STAGES-1];
   assign stage_en  = ready;

endmodule

[rtl/pdps_poly.sv]
// ---------------------------------------------------------------------------
// pdps_poly: pipelined Horner evaluation of the expansivity quartic
// One multiply, shift and add per stage; the pressure divisor is formed in
// the first stage and carried along.
// ---------------------------------------------------------------------------
module pdps_poly import pdps_pkg::*; #(
   parameter int SW = SIDE_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [T_W-1:0]         in_temp,
   input  logic signed [P_W-1:0]  in_pres,
   input  logic [SW-1:0]          in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic signed [H_W-1:0]  out_h,
   output logic [D_W-1:0]         out_d,
   output logic [SW-1:0]          out_side
);

   logic [POLY_STAGES-1:0] en;

   logic signed [H_W-1:0] h_ff    [POLY_STAGES];
   logic [D_W-1:0]        d_ff    [POLY_STAGES];
   logic [SW-1:0]         side_ff [POLY_STAGES];
   logic [T_W-1:0]        t_ff    [POLY_STAGES-1];

   logic [PC_W-1:0]       pc;
   logic [PC_W+PFAC_W-1:0] pc_prod;
   logic [D_W-1:0]        d_in;

   pdps_pipe_ctl #(.STAGES(POLY_STAGES)) u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .stage_en  (en)
   );

   // Negative pressure does not reduce the expansivity.
   always_comb begin
      pc      = in_pres[P_W-1] ? '0 : in_pres[PC_W-1:0];
      pc_prod = pc * PFAC;
      d_in    = ONE48_D + D_W'(pc_prod);
   end

   for (genvar k = 0; k < POLY_STAGES; k++) begin : g_step
      logic signed [H_W-1:0]     h_src;
      logic [T_W-1:0]            t_pass;
      logic [D_W-1:0]            d_src;
      logic [SW-1:0]             side_src;
      logic signed [T_W:0]       t_src;
      logic signed [H_W+T_W:0]   prod;
      logic signed [H_W-1:0]     h_in;

      if (k == 0) begin : g_first
         assign h_src    = POLY_COEF[0];
         assign t_pass   = in_temp;
         assign d_src    = d_in;
         assign side_src = in_side;
      end else begin : g_next
         assign h_src    = h_ff[k-1];
         assign t_pass   = t_ff[k-1];
         assign d_src    = d_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign t_src = $signed({1'b0, t_pass});

      always_comb begin
         prod = h_src * t_src;
         h_in = H_W'(prod >>> POLY_SHIFT[k]) + POLY_COEF[k+1];
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            h_ff[k]    <= h_in;
            d_ff[k]    <= d_src;
            side_ff[k] <= side_src;
         end
      end

      if (k < POLY_STAGES - 1) begin : g_temp
         always_ff @(posedge clock) begin
            if (en[k]) begin
               t_ff[k] <= t_pass;
            end
         end
      end
   end

   assign out_h    = h_ff[POLY_STAGES-1];
   assign out_d    = d_ff[POLY_STAGES-1];
   assign out_side = side_ff[POLY_STAGES-1];

endmodule

[rtl/pdps_div.sv]
// ---------------------------------------------------------------------------
// pdps_div: pipelined restoring divider for the pressure-scaled expansivity
// Forms |h| * 2^40 / d one quotient bit per stage and restores the sign in a
// final stage. The magnitude of h always lies below d.
// ---------------------------------------------------------------------------
module pdps_div import pdps_pkg::*; #(
   parameter int SW = SIDE_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [H_W-1:0]    in_h,
   input  logic [D_W-1:0]           in_d,
   input  logic [SW-1:0]            in_side,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [ALPHA_W-1:0] out_alpha,
   output logic [SW-1:0]            out_side
);

   localparam int NS = DIV_STEPS + 2;

   logic [NS-1:0] en;

   logic [R_W-1:0]  r_ff    [DIV_STEPS];
   logic [D_W-1:0]  d_ff    [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_ff [1:DIV_STEPS];
   logic            neg_ff  [DIV_STEPS+1];
   logic [SW-1:0]   side_ff [NS];
   logic signed [ALPHA_W-1:0] alpha_ff;

   logic [H_W-1:0]  mag;
   logic signed [ALPHA_W-1:0] q_ext;

   pdps_pipe_ctl #(.STAGES(NS)) u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .stage_en  (en)
   );

   assign mag = in_h[H_W-1] ? H_W'(-in_h) : H_W'(in_h);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff[0]    <= R_W'(mag);
         d_ff[0]    <= in_d;
         neg_ff[0]  <= in_h[H_W-1];
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [R_W-1:0]       r2;
      logic [R_W-1:0]       r_in;
      logic                 bit_in;
      logic [DIV_STEPS-1:0] q_src;

      if (k == 1) begin : g_first
         assign q_src = '0;
      end else begin : g_next
         assign q_src = q_ff[k-1];
      end

      always_comb begin
         r2     = {r_ff[k-1][R_W-2:0], 1'b0};
         bit_in = (r2 >= {1'b0, d_ff[k-1]});
         r_in   = bit_in ? (r2 - {1'b0, d_ff[k-1]}) : r2;
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            q_ff[k]    <= {q_src[DIV_STEPS-2:0], bit_in};
            neg_ff[k]  <= neg_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end

      if (k < DIV_STEPS) begin : g_rem
         always_ff @(posedge clock) begin
            if (en[k]) begin
               r_ff[k] <= r_in;
               d_ff[k] <= d_ff[k-1];
            end
         end
      end
   end

   assign q_ext = $signed({1'b0, q_ff[DIV_STEPS]});

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         alpha_ff       <= neg_ff[DIV_STEPS] ? -q_ext : q_ext;
         side_ff[NS-1]  <= side_ff[NS-2];
      end
   end

   assign out_alpha = alpha_ff;
   assign out_side  = side_ff[NS-1];

endmodule

[rtl/pt_density_with_phase_steps.sv]
// ---------------------------------------------------------------------------
// pt_density_with_phase_steps: density of a material point with phase steps
// Evaluates (reference density + phase steps) * (1 + beta*dP - alpha*dT)
// with an optional built-in polynomial expansivity, saturating the result.
// ---------------------------------------------------------------------------
// Usage:
//  Items enter on the req_ stream and leave on the rsp_ stream, one result
//  item per input item, in order. The user must write registers through
//  csr_ only while no item is in flight; the block does not enforce this.
//  From acceptance to rsp_tvalid an item passes through two front stages
//  (differences, boundaries, phase), four Horner stages, 42 divider stages
//  (load, one per quotient bit, sign) and six back stages (thermal product,
//  factor sum, sign handling, split product, sum, rounding).
//  Throughput is one item per cycle unless stalled; a stage holds one item.
//  Reset clears all valid bits and the configuration registers to zero.
//  When the receiver stalls, the stage holding a finished item keeps it and
//  the stages before it keep filling until each holds an item; only then
//  does req_tready fall.
// ---------------------------------------------------------------------------
module pt_density_with_phase_steps import pdps_pkg::*; #(
   parameter logic signed [SLOPE_W-1:0] FIRST_SLOPE  = FIRST_SLOPE_DEFAULT,
   parameter logic signed [SLOPE_W-1:0] SECOND_SLOPE = SECOND_SLOPE_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // temperature[20:0], pressure[48:21], expansivity[80:49],
   // compressibility[112:81], zero fill[119:113]
   input  logic [119:0]         req_tdata,
   // temperature_valid[0], pressure_valid[1]
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // density[31:0], phase[33:32], zero fill[39:34]
   output logic [39:0]          rsp_tdata,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [DEN_W-1:0]        ref_den_ff;
   logic [T_W-1:0]          ref_temp_ff;
   logic signed [P_W-1:0]   ref_pres_ff;
   logic                    poly_mode_ff;
   logic signed [P_W-1:0]   step1_pres_ff;
   logic signed [DEN_W-1:0] step1_den_ff;
   logic signed [P_W-1:0]   step2_pres_ff;
   logic signed [DEN_W-1:0] step2_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_den_ff    <= '0;
         ref_temp_ff   <= '0;
         ref_pres_ff   <= '0;
         poly_mode_ff  <= 1'b0;
         step1_pres_ff <= '0;
         step1_den_ff  <= '0;
         step2_pres_ff <= '0;
         step2_den_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_REF_DENSITY: ref_den_ff    <= csr_wdata[DEN_W-1:0];
            CSR_REF_TEMP:    ref_temp_ff   <= csr_wdata[T_W-1:0];
            CSR_REF_PRES:    ref_pres_ff   <= csr_wdata[P_W-1:0];
            CSR_POLY_MODE:   poly_mode_ff  <= csr_wdata[0];
            CSR_STEP1_PRES:  step1_pres_ff <= csr_wdata[P_W-1:0];
            CSR_STEP1_DEN:   step1_den_ff  <= csr_wdata[DEN_W-1:0];
            CSR_STEP2_PRES:  step2_pres_ff <= csr_wdata[P_W-1:0];
            CSR_STEP2_DEN:   step2_den_ff  <= csr_wdata[DEN_W-1:0];
         endcase
      end
   end

   // Input fields.
   logic [T_W-1:0]          in_temp;
   logic signed [P_W-1:0]   in_pres;
   logic signed [AE_W-1:0]  in_alpha;
   logic signed [BE_W-1:0]  in_beta;

   assign in_temp  = req_tdata[20:0];
   assign in_pres  = req_tdata[48:21];
   assign in_alpha = req_tdata[80:49];
   assign in_beta  = req_tdata[112:81];

   // Front stages.
   logic [1:0] en_f;
   logic       front_valid, poly_in_ready;

   pdps_pipe_ctl #(.STAGES(2)) u_front_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (front_valid),
      .out_ready (poly_in_ready),
      .stage_en  (en_f)
   );

   logic signed [DT_W-1:0]            tk, dt_in;
   logic signed [DP_W-1:0]            dp_in;
   logic signed [SLOPE_W+DT_W-1:0]    sl1_prod, sl2_prod;

   always_comb begin
      tk       = $signed({1'b0, in_temp}) - T273;
      dt_in    = $signed({1'b0, in_temp}) - $signed({1'b0, ref_temp_ff});
      dp_in    = DP_W'(in_pres) - DP_W'(ref_pres_ff);
      sl1_prod = FIRST_SLOPE * tk;
      sl2_prod = SECOND_SLOPE * tk;
   end

   logic [T_W-1:0]           f1_temp;
   logic signed [P_W-1:0]    f1_pres;
   logic                     f1_tv, f1_pv;
   logic signed [AE_W-1:0]   f1_alpha;
   logic signed [DT_W-1:0]   f1_dt;
   logic signed [PRESS_W-1:0] f1_press;
   logic signed [BND_W-1:0]  f1_b1, f1_b2;

   always_ff @(posedge clock) begin
      if (en_f[0]) begin
         f1_temp  <= in_temp;
         f1_pres  <= in_pres;
         f1_tv    <= req_tuser[0];
         f1_pv    <= req_tuser[1];
         f1_alpha <= in_alpha;
         f1_dt    <= dt_in;
         f1_press <= in_beta * dp_in;
         f1_b1    <= BND_W'(sl1_prod >>> 8) + BND_W'(step1_pres_ff);
         f1_b2    <= BND_W'(sl2_prod >>> 8) + BND_W'(step2_pres_ff);
      end
   end

   logic signed [BND_W-1:0]  p_ext;
   logic signed [BASE_W-1:0] base0, base1, base2;
   phase_type                phase_in;
   logic signed [BASE_W-1:0] base_in;

   always_comb begin
      p_ext = BND_W'(f1_pres);
      base0 = $signed({3'b000, ref_den_ff});
      base1 = base0 + BASE_W'(step1_den_ff);
      base2 = base1 + BASE_W'(step2_den_ff);
      // The second boundary wins even when it lies below the first.
      priority if (step1_den_ff == '0) begin
         phase_in = PHASE_LOW;
         base_in  = base0;
      end else if (p_ext > f1_b2) begin
         phase_in = PHASE_HIGH;
         base_in  = base2;
      end else if (p_ext > f1_b1) begin
         phase_in = PHASE_MID;
         base_in  = base1;
      end else begin
         phase_in = PHASE_LOW;
         base_in  = base0;
      end
   end

   logic [T_W-1:0]        f2_temp;
   logic signed [P_W-1:0] f2_pres;
   side_type              f2_side;

   always_ff @(posedge clock) begin
      if (en_f[1]) begin
         f2_temp          <= f1_temp;
         f2_pres          <= f1_pres;
         f2_side.tv       <= f1_tv;
         f2_side.pv       <= f1_pv;
         f2_side.alpha_in <= f1_alpha;
         f2_side.dt       <= f1_dt;
         f2_side.press    <= f1_press;
         f2_side.phase    <= phase_in;
         f2_side.base     <= base_in;
      end
   end

   // Polynomial expansivity and pressure division.
   logic                     poly_valid, div_in_ready;
   logic signed [H_W-1:0]    poly_h;
   logic [D_W-1:0]           poly_d;
   logic [SIDE_W-1:0]        poly_side;
   logic                     div_valid, back_in_ready;
   logic signed [ALPHA_W-1:0] div_alpha;
   logic [SIDE_W-1:0]        div_side;

   pdps_poly #(.SW(SIDE_W)) u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (poly_in_ready),
      .in_temp   (f2_temp),
      .in_pres   (f2_pres),
      .in_side   (f2_side),
      .out_valid (poly_valid),
      .out_ready (div_in_ready),
      .out_h     (poly_h),
      .out_d     (poly_d),
      .out_side  (poly_side)
   );

   pdps_div #(.SW(SIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (poly_valid),
      .in_ready  (div_in_ready),
      .in_h      (poly_h),
      .in_d      (poly_d),
      .in_side   (poly_side),
      .out_valid (div_valid),
      .out_ready (back_in_ready),
      .out_alpha (div_alpha),
      .out_side  (div_side)
   );

   // Back stages.
   logic [5:0] en_b;

   pdps_pipe_ctl #(.STAGES(6)) u_back_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (back_in_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .stage_en  (en_b)
   );

   side_type                  bs;
   logic signed [ALPHA_W-1:0] alpha_sel;

   always_comb begin
      bs        = side_type'(div_side);
      alpha_sel = poly_mode_ff ? div_alpha : ALPHA_W'(bs.alpha_in);
   end

   logic signed [THERM_W-1:0] q1_therm;
   logic signed [PRESS_W-1:0] q1_press;
   logic                      q1_tv, q1_pv;
   phase_type                 q1_phase, q2_phase, q3_phase, q4_phase, q5_phase, q6_phase;
   logic signed [BASE_W-1:0]  q1_base, q2_base;

   always_ff @(posedge clock) begin
      if (en_b[0]) begin
         q1_therm <= alpha_sel * bs.dt;
         q1_press <= bs.press;
         q1_tv    <= bs.tv;
         q1_pv    <= bs.pv;
         q1_phase <= bs.phase;
         q1_base  <= bs.base;
      end
   end

   logic signed [63:0] f_sum;

   always_comb begin
      f_sum = ONE48 - (q1_tv ? 64'(q1_therm) : 64'sd0)
                    + (q1_pv ? 64'(q1_press) : 64'sd0);
   end

   logic signed [F_W-1:0] q2_f;

   always_ff @(posedge clock) begin
      if (en_b[1]) begin
         q2_f     <= F_W'(f_sum);
         q2_phase <= q1_phase;
         q2_base  <= q1_base;
      end
   end

   // A zero or negative product reads as zero density.
   logic                  zero_in;
   logic signed [F_W-1:0] f_abs;
   logic signed [BASE_W-1:0] b_abs;

   always_comb begin
      zero_in = (q2_base == '0) || (q2_f == '0) || (q2_base[BASE_W-1] != q2_f[F_W-1]);
      f_abs   = q2_f[F_W-1] ? -q2_f : q2_f;
      b_abs   = q2_base[BASE_W-1] ? -q2_base : q2_base;
   end

   logic              q3_zero, q4_zero, q5_zero;
   logic [BM_W-1:0]   q3_bm;
   logic [FM_W-1:0]   q3_fm;

   always_ff @(posedge clock) begin
      if (en_b[2]) begin
         q3_zero  <= zero_in;
         q3_bm    <= b_abs[BM_W-1:0];
         q3_fm    <= f_abs[FM_W-1:0];
         q3_phase <= q2_phase;
      end
   end

   logic [BM_W+FLO_W-1:0] q4_pp_lo;
   logic [BM_W+FHI_W-1:0] q4_pp_hi;

   always_ff @(posedge clock) begin
      if (en_b[3]) begin
         q4_pp_lo <= q3_bm * q3_fm[FLO_W-1:0];
         q4_pp_hi <= q3_bm * q3_fm[FM_W-1:FLO_W];
         q4_zero  <= q3_zero;
         q4_phase <= q3_phase;
      end
   end

   logic [PROD_W-1:0] q5_prod;

   always_ff @(posedge clock) begin
      if (en_b[4]) begin
         q5_prod  <= {q4_pp_hi, {FLO_W{1'b0}}} + PROD_W'(q4_pp_lo);
         q5_zero  <= q4_zero;
         q5_phase <= q4_phase;
      end
   end

   logic [PROD_W:0]   rnd;
   logic [DEN_W-1:0]  den_in;

   always_comb begin
      rnd = {1'b0, q5_prod} + ((PROD_W + 1)'(1) << (FRAC_SH - 1));
      if (q5_zero) begin
         den_in = '0;
      end else if (rnd[PROD_W:FRAC_SH+DEN_W] != '0) begin
         den_in = '1;
      end else begin
         den_in = rnd[FRAC_SH+DEN_W-1:FRAC_SH];
      end
   end

   logic [DEN_W-1:0] q6_den;

   always_ff @(posedge clock) begin
      if (en_b[5]) begin
         q6_den   <= den_in;
         q6_phase <= q5_phase;
      end
   end

   assign rsp_tdata = {6'b000000, q6_phase, q6_den};

   // Checks.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled while the output is free");

   a_phase_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && step1_den_ff == '0 |-> rsp_tdata[33:32] == PH_W'(PHASE_LOW))
      else $error("phase reported while phase steps are disabled");

   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] != 2'b11)
      else $error("unused phase code on output");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:34] == '0)
      else $error("output fill bits set");

endmodule

[tb/sv/pt_density_with_phase_steps_tb.sv]
// ---------------------------------------------------------------------------
// pt_density_with_phase_steps_tb: self-checking bench of the density block
// Drives material points through the req_ stream, predicts density and phase
// for every accepted item, and checks each rsp_ item in order. Registers are
// rewritten between phases while the block is idle. Sender and receiver
// stall at random, except in the last phases, where neither stalls.
// ---------------------------------------------------------------------------
module pt_density_with_phase_steps_tb;
   import pdps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 70;
   localparam int STALL_LIMIT  = 3000;
   localparam int NUM_PHASES   = 10;
   localparam int PHASE_ITEMS  = 125;
   localparam longint BND_SLOPE1 = 0;
   localparam longint BND_SLOPE2 = 0;
   localparam longint KELVIN_273 = 69888;
   localparam longint HC4 = -64'sd638483916068;
   localparam longint HC3 = 64'sd945844218453;
   localparam longint HC2 = -64'sd124410744991;
   localparam longint HC1 = 64'sd30195014206;
   localparam longint HC0 = 64'sd1321440573;
   localparam longint PRES_FACTOR = 7864411;

   typedef struct {
      logic [20:0]        temp;
      logic               temp_ok;
      logic signed [27:0] pres;
      logic               pres_ok;
      logic signed [31:0] alpha;
      logic signed [31:0] beta;
   } point_type;

   typedef struct {
      logic [31:0] density;
      phase_type   phase;
   } density_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [119:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   point_type   pending_points[$];
   density_type expected_densities[$];
   point_type   cur_point;
   int          fail_count = 0;
   int          send_idle = 18;
   int          recv_idle = 65;
   int          stall_cycles = 0;

   // Register copies used by the predictor.
   logic [31:0]        ref_den = '0;
   logic [20:0]        ref_temp = '0;
   logic signed [27:0] ref_pres = '0;
   logic               poly_mode = 1'b0;
   logic signed [27:0] step1_pres = '0;
   logic signed [31:0] step1_den = '0;
   logic signed [27:0] step2_pres = '0;
   logic signed [31:0] step2_den = '0;

   pt_density_with_phase_steps dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint poly_expansivity(longint t, longint p);
      logic signed [127:0] h, tt, d, mag, q;
      longint pc;
      pc = p > 0 ? p : 0;
      tt = t;
      h = HC4;
      h = ((h * tt) >>> 20) + HC3;
      h = ((h * tt) >>> 22) + HC2;
      h = ((h * tt) >>> 20) + HC1;
      h = ((h * tt) >>> 18) + HC0;
      d = (128'sd1 <<< 48) + pc * PRES_FACTOR;
      mag = h < 0 ? -h : h;
      q = (mag <<< 40) / d;
      return h < 0 ? longint'(-q) : longint'(q);
   endfunction

   function automatic density_type predict_density(point_type pt);
      density_type r;
      longint t, p, f, base, b1, b2, alpha;
      logic signed [127:0] bb, ff, prod, rnd;
      t = pt.temp;
      p = pt.pres;
      f = 64'sd1 <<< 48;
      base = ref_den;
      r.phase = PHASE_LOW;
      if (pt.temp_ok) begin
         alpha = poly_mode ? poly_expansivity(t, p) : longint'(pt.alpha);
         f = f - alpha * (t - longint'(ref_temp));
      end
      if (pt.pres_ok) f = f + longint'(pt.beta) * (p - longint'(ref_pres));
      if (step1_den != 0) begin
         b1 = longint'(step1_pres) + ((BND_SLOPE1 * (t - KELVIN_273)) >>> 8);
         b2 = longint'(step2_pres) + ((BND_SLOPE2 * (t - KELVIN_273)) >>> 8);
         if (p > b2) begin
            r.phase = PHASE_HIGH;
            base = base + longint'(step1_den) + longint'(step2_den);
         end else if (p > b1) begin
            r.phase = PHASE_MID;
            base = base + longint'(step1_den);
         end
      end
      bb = base;
      ff = f;
      prod = bb * ff;
      if (prod <= 0) begin
         r.density = '0;
      end else begin
         rnd = (prod + (128'sd1 <<< 47)) >>> 48;
         r.density = rnd > 128'sd4294967295 ? 32'hFFFF_FFFF : rnd[31:0];
      end
      return r;
   endfunction

   // Driver: a held item stays until accepted.
   always @(posedge clock) begin
      if (!reset && (!req_tvalid || req_tready)) begin
         if (req_tvalid) expected_densities.push_back(predict_density(cur_point));
         if (pending_points.size() > 0 && $urandom_range(99) >= send_idle) begin
            cur_point = pending_points.pop_front();
            req_tdata <= {7'b0, cur_point.beta, cur_point.alpha, cur_point.pres,
                          cur_point.temp};
            req_tuser <= {cur_point.pres_ok, cur_point.temp_ok};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor, receiver stalls and watchdog.
   always @(posedge clock) begin
      density_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_densities.size() == 0) begin
               $error("result item with no expectation: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_densities.pop_front();
               if (rsp_tdata[31:0] !== want.density) begin
                  $error("density: expected %h actual %h", want.density, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[33:32] !== want.phase) begin
                  $error("phase: expected %0d actual %0d", want.phase, rsp_tdata[33:32]);
                  fail_count++;
               end
            end
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
         rsp_tready <= $urandom_range(99) >= recv_idle;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [31:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_REF_DENSITY: ref_den = v;
         CSR_REF_TEMP:    ref_temp = v[20:0];
         CSR_REF_PRES:    ref_pres = v[27:0];
         CSR_POLY_MODE:   poly_mode = v[0];
         CSR_STEP1_PRES:  step1_pres = v[27:0];
         CSR_STEP1_DEN:   step1_den = v;
         CSR_STEP2_PRES:  step2_pres = v[27:0];
         default:         step2_den = v;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_points.size() > 0 || req_tvalid || expected_densities.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic point_type mk_point(logic [20:0] t, logic tv, logic signed [27:0] p,
                                          logic pv, logic signed [31:0] a,
                                          logic signed [31:0] b);
      point_type pt;
      pt.temp = t; pt.temp_ok = tv; pt.pres = p; pt.pres_ok = pv;
      pt.alpha = a; pt.beta = b;
      return pt;
   endfunction

   function automatic point_type random_point();
      point_type pt;
      if ($urandom_range(3) != 0) begin
         // Physically plausible ranges, so results stay off saturation.
         pt = mk_point(21'($urandom_range(3000 * 256, 150 * 256)), $urandom_range(9) != 0,
                       28'($urandom_range(20_000_000) - 2_000_000),
                       $urandom_range(9) != 0,
                       $urandom_range(80_000_000), $urandom_range(6_000_000));
      end else begin
         pt = mk_point(21'($urandom), 1'($urandom), 28'($urandom), 1'($urandom),
                       $urandom, $urandom);
      end
      return pt;
   endfunction

   function automatic logic [31:0] pick_value(logic [31:0] lo, logic [31:0] hi,
                                              logic [31:0] typical);
      case ($urandom_range(5))
         0: return lo;
         1: return hi;
         2: return $urandom;
         default: return typical;
      endcase
   endfunction

   initial begin
      logic [31:0] p1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed phase with boundaries at 1 and 5 GPa.
      write_reg(CSR_REF_DENSITY, 32'd3300 << 16);
      write_reg(CSR_REF_TEMP, 21'd300 * 256);
      write_reg(CSR_REF_PRES, 32'd0);
      write_reg(CSR_POLY_MODE, 32'd1);
      write_reg(CSR_STEP1_PRES, 32'd1_000_000);
      write_reg(CSR_STEP1_DEN, 32'd100 << 16);
      write_reg(CSR_STEP2_PRES, 32'd5_000_000);
      write_reg(CSR_STEP2_DEN, 32'd50 << 16);
      pending_points.push_back(mk_point(21'd0, 1'b1, 28'sd0, 1'b1, 32'sd0, 32'sd0));
      pending_points.push_back(mk_point(21'h1FFFFF, 1'b1, 28'sd0, 1'b1, 32'sd0, 32'sd0));
      pending_points.push_back(mk_point(21'd76800, 1'b1, 28'sd0, 1'b1, 32'sd0, 32'sd0));
      pending_points.push_back(mk_point(21'd76800, 1'b1, 28'sh8000000, 1'b1, 0,
                                        32'sd2_000_000));
      pending_points.push_back(mk_point(21'd76800, 1'b1, 28'sh7FFFFFF, 1'b1, 0,
                                        32'sd2_000_000));
      pending_points.push_back(mk_point(21'd90000, 1'b1, 28'sd1_000_000, 1'b1, 0,
                                        32'sd2_000_000));
      pending_points.push_back(mk_point(21'd90000, 1'b1, 28'sd1_000_001, 1'b1, 0,
                                        32'sd2_000_000));
      pending_points.push_back(mk_point(21'd90000, 1'b1, 28'sd5_000_000, 1'b1, 0,
                                        32'sd2_000_000));
      pending_points.push_back(mk_point(21'd90000, 1'b1, 28'sd5_000_001, 1'b1, 0,
                                        32'sd2_000_000));
      // Invalid temperature, then invalid pressure, which still steers phase and alpha.
      pending_points.push_back(mk_point(21'd500000, 1'b0, 28'sd3_000_000, 1'b1, 0,
                                        32'sd1000));
      pending_points.push_back(mk_point(21'd500000, 1'b1, 28'sd7_000_000, 1'b0, 0,
                                        32'h7FFFFFFF));
      pending_points.push_back(mk_point(21'd500000, 1'b0, 28'sd7_000_000, 1'b0, -1, -1));
      pending_points.push_back(mk_point(21'h1FFFFF, 1'b1, 28'sh7FFFFFF, 1'b1,
                                        32'sh7FFFFFFF, 32'sh80000000));
      pending_points.push_back(mk_point(21'h1FFFFF, 1'b1, 28'sh8000000, 1'b1,
                                        32'sh80000000, 32'sh7FFFFFFF));
      wait_idle();
      // Input expansivity, extremes of alpha and beta.
      write_reg(CSR_POLY_MODE, 32'd0);
      pending_points.push_back(mk_point(21'd0, 1'b1, 28'sd0, 1'b1, 32'sh80000000, 32'sd0));
      pending_points.push_back(mk_point(21'h1FFFFF, 1'b1, 28'sd0, 1'b1, 32'sh7FFFFFFF,
                                        32'sd0));
      pending_points.push_back(mk_point(21'h1FFFFF, 1'b1, 28'sd0, 1'b1, 32'sh80000000,
                                        32'sd0));
      pending_points.push_back(mk_point(21'd76800, 1'b1, 28'sh7FFFFFF, 1'b1, 0,
                                        32'sh7FFFFFFF));
      pending_points.push_back(mk_point(21'd76800, 1'b1, 28'sh7FFFFFF, 1'b1, 0,
                                        32'sh80000000));
      wait_idle();
      // Crossed boundaries and phase logic disabled.
      write_reg(CSR_STEP2_PRES, 32'd500_000);
      pending_points.push_back(mk_point(21'd76800, 1'b1, 28'sd700_000, 1'b1, 0, 0));
      pending_points.push_back(mk_point(21'd76800, 1'b1, 28'sd2_000_000, 1'b1, 0, 0));
      wait_idle();
      write_reg(CSR_STEP1_DEN, 32'd0);
      pending_points.push_back(mk_point(21'd76800, 1'b1, 28'sd9_000_000, 1'b1, 0, 0));
      wait_idle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 3) begin send_idle = 65; recv_idle = 18; end
         if (ph == 7) begin send_idle = 0;  recv_idle = 0;  end
         write_reg(CSR_REF_DENSITY, pick_value(0, 32'hFFFFFFFF, $urandom_range(5000 << 16)));
         write_reg(CSR_REF_TEMP, pick_value(0, 32'h1FFFFF, $urandom_range(2000 * 256)));
         write_reg(CSR_REF_PRES, pick_value(32'h8000000, 32'h7FFFFFF,
                                            $urandom_range(200_000)));
         write_reg(CSR_POLY_MODE, ph % 2);
         p1 = pick_value(32'h8000000, 32'h7FFFFFF, $urandom_range(12_000_000));
         write_reg(CSR_STEP1_PRES, p1);
         write_reg(CSR_STEP1_DEN, ph == 4 ? 32'd0 :
                   pick_value(32'h80000000, 32'h7FFFFFFF, $urandom_range(400 << 16)));
         write_reg(CSR_STEP2_PRES, pick_value(32'h8000000, 32'h7FFFFFF,
                                              $urandom_range(18_000_000)));
         write_reg(CSR_STEP2_DEN, pick_value(32'h80000000, 32'h7FFFFFFF,
                                             $urandom_range(300 << 16)));
         for (int i = 0; i < PHASE_ITEMS; i++) pending_points.push_back(random_point());
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
